// ===== rtl/core/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, constants and helpers of the tar stream parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Widths of the result fields
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ID_W     = 24;
    localparam int unsigned NUM_W    = 36;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

    // Header layout, byte offsets within a 512-byte block
    localparam logic [8:0] OFF_MODE   = 9'd100;
    localparam logic [8:0] OFF_UID    = 9'd108;
    localparam logic [8:0] OFF_GID    = 9'd116;
    localparam logic [8:0] OFF_SIZE   = 9'd124;
    localparam logic [8:0] OFF_MTIME  = 9'd136;
    localparam logic [8:0] OFF_CKSUM  = 9'd148;
    localparam logic [8:0] OFF_TYPE   = 9'd156;
    localparam logic [8:0] OFF_MAGIC  = 9'd257;
    localparam logic [8:0] OFF_MAGEND = 9'd262;
    localparam logic [8:0] OFF_PREFIX = 9'd345;
    localparam logic [8:0] OFF_LAST   = 9'd511;

    localparam logic [35:0] SIZE_LIMIT_RESET = 36'd536870912;

    // Type characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Result queue
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_SKIP,
        SCAN_DIGITS,
        SCAN_STOP
    } scan_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     mode;
        logic [ID_W-1:0]     uid;
        logic [ID_W-1:0]     gid;
        logic [NUM_W-1:0]    size;
        logic [NUM_W-1:0]    mtime;
        logic [7:0]          etype;
        logic                prefix;
        logic [7:0]          pbyte;
        logic                elast;
        logic                slast;
    } res_t;

    // Plain result: every payload field zero
    function automatic res_t res_simple(input logic [KIND_W-1:0] kind,
                                        input logic [STATUS_W-1:0] status);
        res_t r;
        r        = '0;
        r.kind   = kind;
        r.status = status;
        return r;
    endfunction

    // Characters of the ustar magic
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/tsp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// tsp_result_fifo
// Small result queue: takes up to two results a cycle, gives one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
module tsp_result_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_cnt,
    input  tsp_pkg::res_t push0,
    input  tsp_pkg::res_t push1,
    output logic          room_two,
    output logic          out_valid,
    input  logic          out_ready,
    output tsp_pkg::res_t out_data
);
    import tsp_pkg::*;

    res_t              mem_reg [RES_DEPTH];
    logic [RES_AW-1:0] head_reg, tail_reg;
    logic [RES_AW:0]   count_reg;
    logic              pop;
    logic [RES_AW-1:0] tail_p1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign room_two  = (count_reg <= (RES_AW+1)'(RES_DEPTH - 2));
    assign tail_p1   = tail_reg + 1'b1;

    // storage
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[tail_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[tail_p1] <= push1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (pop) begin
                head_reg <= head_reg + 1'b1;
            end
            tail_reg  <= tail_reg + RES_AW'(push_cnt);
            count_reg <= count_reg + (RES_AW+1)'(push_cnt) - (RES_AW+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/tar_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tar_stream_parser
// Byte-serial ustar archive reader with header checks and payload pass-on.
// ----------------------------------------------------------------------------
// One archive byte is taken per clock cycle whenever the four-entry result
// queue has room for two results; the byte is parsed in the same cycle and its
// results (at most two) appear on the m_ channel from the next cycle. With the
// result side always ready the parser sustains one byte per cycle. Header
// fields are decoded on the fly, so the checksum, size and type checks are
// done on the last byte of each header block. After an error or the end of
// the archive every byte is taken and dropped until reset.
module tar_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [35:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [2:0]  m_status_code,
    output logic [23:0] m_file_mode,
    output logic [23:0] m_owner_id,
    output logic [23:0] m_group_id,
    output logic [35:0] m_entry_size,
    output logic [35:0] m_mod_time,
    output logic [7:0]  m_entry_type,
    output logic        m_prefix_used,
    output logic [7:0]  m_payload_byte,
    output logic        m_entry_last,
    output logic        m_step_last
);
    import tsp_pkg::*;

    // state
    logic [35:0]        limit_reg;
    logic [8:0]         off_reg;
    phase_t             phase_reg, phase_next;
    logic [16:0]        usum_reg, usum_next;
    logic signed [17:0] ssum_reg, ssum_next;
    logic [23:0]        stored_reg, stored_next;
    scan_t              scan_reg, scan_next;
    logic [23:0]        mode_reg, mode_next, uid_reg, uid_next, gid_reg, gid_next;
    logic [35:0]        size_reg, size_next, time_reg, time_next;
    logic [7:0]         type_reg, type_next;
    logic [2:0]         magic_reg, magic_next;
    logic               prefix_reg, prefix_next;
    logic               zero_reg, zero_next;
    logic [1:0]         zblk_reg, zblk_next;
    logic [35:0]        left_reg, left_next;

    // step logic
    logic        take, clr, last, ends, room_two;
    logic [7:0]  b, b_sum;
    logic        in_num, digit, feed;
    logic [2:0]  fsel;
    scan_t       scan_base;
    logic [2:0]  midx;
    logic [7:0]  etype;
    logic        cks_ok;
    logic [1:0]  zb_inc;
    logic [1:0]  n_res;
    res_t        r0, r1, hdr, out_res;

    assign take = s_valid && s_ready;
    assign b    = s_data_byte;
    assign ends = s_stream_end;
    assign clr  = (off_reg == 9'd0);
    assign last = (off_reg == OFF_LAST);
    assign s_ready = room_two;

    // field select for the octal fields: 0 none, 1 mode .. 6 checksum
    always_comb begin
        priority if (off_reg >= OFF_MODE && off_reg < OFF_UID)    fsel = 3'd1;
        else if (off_reg >= OFF_UID && off_reg < OFF_GID)         fsel = 3'd2;
        else if (off_reg >= OFF_GID && off_reg < OFF_SIZE)        fsel = 3'd3;
        else if (off_reg >= OFF_SIZE && off_reg < OFF_MTIME)      fsel = 3'd4;
        else if (off_reg >= OFF_MTIME && off_reg < OFF_CKSUM)     fsel = 3'd5;
        else if (off_reg >= OFF_CKSUM && off_reg < OFF_TYPE)      fsel = 3'd6;
        else                                                      fsel = 3'd0;
    end

    assign in_num = (fsel != 3'd0);
    assign digit  = (b >= CH_ZERO) && (b <= CH_SEVEN);
    assign midx   = 3'(off_reg - OFF_MAGIC);

    // octal scan: skip blanks, take digits, stop at anything else
    always_comb begin
        scan_base = (off_reg == OFF_MODE || off_reg == OFF_UID || off_reg == OFF_GID ||
                     off_reg == OFF_SIZE || off_reg == OFF_MTIME || off_reg == OFF_CKSUM)
                    ? SCAN_SKIP : scan_reg;
        scan_next = scan_base;
        feed      = 1'b0;
        if (in_num) begin
            if (scan_base == SCAN_SKIP && b != CH_SPACE && b != 8'h00) begin
                scan_next = SCAN_DIGITS;
            end
            if (scan_next == SCAN_DIGITS) begin
                if (digit) begin
                    feed = 1'b1;
                end else begin
                    scan_next = SCAN_STOP;
                end
            end
        end
    end

    // header accumulation
    always_comb begin
        b_sum       = (fsel == 3'd6) ? CH_SPACE : b;
        usum_next   = (clr ? 17'd0 : usum_reg) + {9'd0, b_sum};
        ssum_next   = (clr ? 18'sd0 : ssum_reg) + $signed({{10{b_sum[7]}}, b_sum});
        stored_next = clr ? 24'd0 : stored_reg;
        mode_next   = clr ? 24'd0 : mode_reg;
        uid_next    = clr ? 24'd0 : uid_reg;
        gid_next    = clr ? 24'd0 : gid_reg;
        size_next   = clr ? 36'd0 : size_reg;
        time_next   = clr ? 36'd0 : time_reg;
        type_next   = clr ? 8'd0 : type_reg;
        magic_next  = clr ? 3'd0 : magic_reg;
        prefix_next = clr ? 1'b0 : prefix_reg;
        zero_next   = (clr ? 1'b1 : zero_reg) && (b == 8'h00);
        if (feed) begin
            unique case (fsel)
                3'd1:    mode_next   = {mode_next[20:0], b[2:0]};
                3'd2:    uid_next    = {uid_next[20:0], b[2:0]};
                3'd3:    gid_next    = {gid_next[20:0], b[2:0]};
                3'd4:    size_next   = {size_next[32:0], b[2:0]};
                3'd5:    time_next   = {time_next[32:0], b[2:0]};
                3'd6:    stored_next = {stored_next[20:0], b[2:0]};
                default: ;
            endcase
        end
        if (off_reg == OFF_TYPE) begin
            type_next = b;
        end
        if (off_reg >= OFF_MAGIC && off_reg < OFF_MAGEND) begin
            if (magic_next == midx && b == magic_char(midx)) begin
                magic_next = midx + 3'd1;
            end
        end
        if (off_reg == OFF_PREFIX) begin
            prefix_next = (b != 8'h00);
        end
    end

    // header result record and checks
    always_comb begin
        etype       = (type_next == 8'h00) ? CH_ZERO : type_next;
        cks_ok      = ({7'd0, usum_next} == stored_next) ||
                      (!ssum_next[17] && {6'd0, ssum_next} == stored_next);
        zb_inc      = (zblk_reg == 2'd2) ? 2'd2 : zblk_reg + 2'd1;
        hdr         = res_simple(KIND_HEADER, ST_OK);
        hdr.mode    = mode_next;
        hdr.uid     = uid_next;
        hdr.gid     = gid_next;
        hdr.size    = size_next;
        hdr.mtime   = time_next;
        hdr.etype   = etype;
        hdr.prefix  = (magic_next == 3'd5) && prefix_next;
    end

    // results and control for one byte
    always_comb begin
        phase_next = phase_reg;
        zblk_next  = zblk_reg;
        left_next  = left_reg;
        n_res      = 2'd0;
        r0         = res_simple(KIND_END, ST_OK);
        r1         = res_simple(KIND_END, ST_OK);
        unique case (phase_reg)
            PH_HEADER: begin
                if (last) begin
                    if (zero_next) begin
                        zblk_next = zb_inc;
                        if (zb_inc == 2'd2 || ends) begin
                            phase_next = PH_DONE;
                            n_res      = 2'd1;
                        end
                    end else begin
                        zblk_next = 2'd0;
                        n_res     = 2'd1;
                        if (!cks_ok) begin
                            phase_next = PH_DONE;
                            r0         = res_simple(KIND_ERROR, ST_CHECKSUM);
                        end else if (size_next > limit_reg) begin
                            phase_next = PH_DONE;
                            r0         = res_simple(KIND_ERROR, ST_OVERSIZE);
                        end else begin
                            r0 = hdr;
                            if (etype == CH_ZERO && size_next != 36'd0) begin
                                left_next = size_next;
                                if (ends) begin
                                    phase_next = PH_DONE;
                                    n_res      = 2'd2;
                                    r1 = res_simple(KIND_ERROR, ST_TRUNCATED);
                                end else begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end else if (etype != CH_ZERO && etype != CH_ONE &&
                                         etype != CH_TWO && etype != CH_FIVE) begin
                                phase_next = PH_DONE;
                                n_res      = 2'd2;
                                r1 = res_simple(KIND_ERROR, ST_BAD_TYPE);
                            end else if (ends) begin
                                phase_next = PH_DONE;
                                n_res      = 2'd2;
                            end
                        end
                    end
                end else if (ends) begin
                    phase_next = PH_DONE;
                    n_res      = 2'd1;
                    if (zblk_reg == 2'd0) begin
                        r0 = res_simple(KIND_ERROR, ST_TRUNCATED);
                    end
                end
            end
            PH_PAYLOAD: begin
                if (left_reg != 36'd0) begin
                    left_next = left_reg - 36'd1;
                    r0        = res_simple(KIND_PAYLOAD, ST_OK);
                    r0.pbyte  = b;
                    r0.elast  = (left_next == 36'd0);
                    n_res     = 2'd1;
                end
                if (ends) begin
                    phase_next = PH_DONE;
                    if (n_res == 2'd1) begin
                        n_res = 2'd2;
                        if (!(last && left_next == 36'd0)) begin
                            r1 = res_simple(KIND_ERROR, ST_TRUNCATED);
                        end
                    end else begin
                        n_res = 2'd1;
                        if (!(last && left_next == 36'd0)) begin
                            r0 = res_simple(KIND_ERROR, ST_TRUNCATED);
                        end
                    end
                end else if (last && left_next == 36'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            default: ;
        endcase
        r0.slast = (n_res == 2'd1);
        r1.slast = 1'b1;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= SIZE_LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg    <= '0;
            phase_reg  <= PH_HEADER;
            usum_reg   <= '0;
            ssum_reg   <= '0;
            stored_reg <= '0;
            scan_reg   <= SCAN_SKIP;
            mode_reg   <= '0;
            uid_reg    <= '0;
            gid_reg    <= '0;
            size_reg   <= '0;
            time_reg   <= '0;
            type_reg   <= '0;
            magic_reg  <= '0;
            prefix_reg <= 1'b0;
            zero_reg   <= 1'b1;
            zblk_reg   <= '0;
            left_reg   <= '0;
        end else if (take && phase_reg != PH_DONE) begin
            off_reg   <= off_reg + 9'd1;
            phase_reg <= phase_next;
            zblk_reg  <= zblk_next;
            left_reg  <= left_next;
            if (phase_reg == PH_HEADER) begin
                usum_reg   <= usum_next;
                ssum_reg   <= ssum_next;
                stored_reg <= stored_next;
                scan_reg   <= scan_next;
                mode_reg   <= mode_next;
                uid_reg    <= uid_next;
                gid_reg    <= gid_next;
                size_reg   <= size_next;
                time_reg   <= time_next;
                type_reg   <= type_next;
                magic_reg  <= magic_next;
                prefix_reg <= prefix_next;
                zero_reg   <= zero_next;
            end
        end
    end

    // result queue
    tsp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  ((take && phase_reg != PH_DONE) ? n_res : 2'd0),
        .push0     (r0),
        .push1     (r1),
        .room_two  (room_two),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_result_kind  = out_res.kind;
    assign m_status_code  = out_res.status;
    assign m_file_mode    = out_res.mode;
    assign m_owner_id     = out_res.uid;
    assign m_group_id     = out_res.gid;
    assign m_entry_size   = out_res.size;
    assign m_mod_time     = out_res.mtime;
    assign m_entry_type   = out_res.etype;
    assign m_prefix_used  = out_res.prefix;
    assign m_payload_byte = out_res.pbyte;
    assign m_entry_last   = out_res.elast;
    assign m_step_last    = out_res.slast;

endmodule

// ===== rtl/core/tsp_checker.sv =====
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tar stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [2:0] m_status_code,
    input logic [7:0] m_payload_byte,
    input logic       m_entry_last,
    input logic       m_step_last
);
    import tsp_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind))
        else $error("result changed while stalled");

    // status only on errors
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_ERROR |-> m_status_code == ST_OK)
        else $error("status on a non-error result");

    // payload fields only on payload results
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_PAYLOAD |-> m_payload_byte == 8'h00 && !m_entry_last)
        else $error("payload fields on a non-payload result");

    // end or error is final: nothing follows it
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_result_kind == KIND_END || m_result_kind == KIND_ERROR)
        |-> m_step_last ##1 !m_valid)
        else $error("result after end of archive or error");

endmodule

bind tar_stream_parser tsp_checker u_tsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_kind  (m_result_kind),
    .m_status_code  (m_status_code),
    .m_payload_byte (m_payload_byte),
    .m_entry_last   (m_entry_last),
    .m_step_last    (m_step_last)
);
